// File: src/csvfs_pkg.sv
// ----------------------------------------------------------------------------
// csvfs_pkg
// Types and constants shared by the delimited-text field splitter.
// ----------------------------------------------------------------------------
package csvfs_pkg;

    // One input request: a text byte or an end-of-stream mark.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_csv_in;

    // One result per request.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       field_begin;
        logic       field_done;
        logic       row_done;
        logic [7:0] column_index;
    } t_csv_out;

    // Parse state, one-hot.
    typedef enum logic [3:0] {
        MODE_START  = 4'b0001,  // awaiting field start
        MODE_PLAIN  = 4'b0010,  // inside unquoted text
        MODE_QUOTED = 4'b0100,  // inside quoted text
        MODE_AFTERQ = 4'b1000   // quote seen inside quoted text
    } t_mode;

    // Configuration register indexes (byte address = 4 * index).
    localparam logic [1:0] REG_FIELD_SEP = 2'd0;
    localparam logic [1:0] REG_QUOTE     = 2'd1;
    localparam logic [1:0] REG_ROW_TERM  = 2'd2;

    localparam logic [7:0] RST_FIELD_SEP = 8'd44;  // ','
    localparam logic [7:0] RST_QUOTE     = 8'd34;  // '"'
    localparam logic [7:0] RST_ROW_TERM  = 8'd10;  // LF

endpackage

// File: src/csv_field_splitter.sv
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits a byte stream of delimited text into fields and rows.
// ----------------------------------------------------------------------------
// Accepts one byte (or end-of-stream mark) per clock while the output register
// is not stalled and returns one result per request, in order. A request sits
// in the input register, where the parse state and column counter are updated,
// and its result is then held in the output register until taken. A stalled
// output register stops the input register from advancing.
// Delimiter bytes are set through the APB port (field separator at 0x0, quote
// at 0x4, row terminator at 0x8) and should be changed only while idle. The
// column index saturates at the smaller of MAX_COLUMNS-1 and 255.
module csv_field_splitter #(
    parameter int unsigned MAX_COLUMNS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  csvfs_pkg::t_csv_in  i_in,

    output logic                o_out_valid,
    input  logic                i_out_stall,
    output csvfs_pkg::t_csv_out o_out,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import csvfs_pkg::*;

    localparam int unsigned ColLimitInt = (MAX_COLUMNS - 1 > 255) ? 255 : MAX_COLUMNS - 1;
    localparam logic [7:0]  ColLimit    = 8'(ColLimitInt);

    logic [7:0] r_field_sep;
    logic [7:0] r_quote;
    logic [7:0] r_row_term;

    logic       r_in_valid;
    t_csv_in    r_in;
    logic       r_out_valid;
    t_csv_out   r_out;
    t_mode      r_mode;
    logic [7:0] r_col;

    t_mode      n_mode;
    logic [7:0] n_col;
    t_csv_out   n_out;

    logic       out_load;
    logic       advance;
    logic       in_take;
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_sep <= RST_FIELD_SEP;
            r_quote     <= RST_QUOTE;
            r_row_term  <= RST_ROW_TERM;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FIELD_SEP: r_field_sep <= pwdata[7:0];
                REG_QUOTE:     r_quote     <= pwdata[7:0];
                REG_ROW_TERM:  r_row_term  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_FIELD_SEP: prdata = {24'd0, r_field_sep};
            REG_QUOTE:     prdata = {24'd0, r_quote};
            REG_ROW_TERM:  prdata = {24'd0, r_row_term};
            default:       prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    assign out_load   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------- parse step ----------------
    always_comb begin
        logic eoi;
        logic is_row;
        logic is_sep;
        logic is_quote;

        eoi      = r_in.end_of_input;
        is_row   = eoi || (r_in.in_byte == r_row_term);
        is_sep   = r_in.in_byte == r_field_sep;
        is_quote = r_in.in_byte == r_quote;

        n_mode             = r_mode;
        n_out.out_byte     = 8'd0;
        n_out.byte_valid   = 1'b0;
        n_out.field_begin  = 1'b0;
        n_out.field_done   = 1'b0;
        n_out.row_done     = 1'b0;
        n_out.column_index = r_col;

        case (r_mode)
            MODE_START: begin
                if (is_row) begin
                    n_out.row_done = 1'b1;
                end else begin
                    n_out.field_begin = 1'b1;
                    if (is_sep) begin
                        n_out.field_done = 1'b1;
                    end else if (is_quote) begin
                        n_mode = MODE_QUOTED;
                    end else begin
                        n_out.byte_valid = 1'b1;
                        n_out.out_byte   = r_in.in_byte;
                        n_mode           = MODE_PLAIN;
                    end
                end
            end
            MODE_PLAIN: begin
                if (is_row) begin
                    n_out.field_done = 1'b1;
                    n_out.row_done   = 1'b1;
                end else if (is_sep) begin
                    n_out.field_done = 1'b1;
                end else if (is_quote) begin
                    n_mode = MODE_QUOTED;
                end else begin
                    n_out.byte_valid = 1'b1;
                    n_out.out_byte   = r_in.in_byte;
                end
            end
            MODE_QUOTED: begin
                // unterminated quote at end of stream closes field and row
                if (eoi) begin
                    n_out.field_done = 1'b1;
                    n_out.row_done   = 1'b1;
                end else if (is_quote) begin
                    n_mode = MODE_AFTERQ;
                end else begin
                    n_out.byte_valid = 1'b1;
                    n_out.out_byte   = r_in.in_byte;
                end
            end
            MODE_AFTERQ: begin
                if (eoi) begin
                    n_out.field_done = 1'b1;
                    n_out.row_done   = 1'b1;
                end else if (is_quote) begin
                    // doubled quote: emit one quote byte
                    n_out.byte_valid = 1'b1;
                    n_out.out_byte   = r_in.in_byte;
                    n_mode           = MODE_QUOTED;
                end else if (r_in.in_byte == r_row_term) begin
                    n_out.field_done = 1'b1;
                    n_out.row_done   = 1'b1;
                end else if (is_sep) begin
                    n_out.field_done = 1'b1;
                end else begin
                    n_out.byte_valid = 1'b1;
                    n_out.out_byte   = r_in.in_byte;
                    n_mode           = MODE_PLAIN;
                end
            end
            default: begin
                n_mode = MODE_START;
            end
        endcase

        n_col = r_col;
        if (n_out.row_done) begin
            n_mode = MODE_START;
            n_col  = 8'd0;
        end else if (n_out.field_done) begin
            n_mode = MODE_START;
            if (r_col < ColLimit) begin
                n_col = r_col + 8'd1;
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_START;
            r_col       <= 8'd0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_mode <= n_mode;
                r_col  <= n_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // ---------------- assertions ----------------
    a_col_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= ColLimit)
        else $error("column counter beyond its limit");

    a_row_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_out.row_done) |=> (r_col == 8'd0 && r_mode == MODE_START))
        else $error("row end did not clear column counter and parse state");

    a_begin_not_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.field_begin) |-> !r_out.row_done)
        else $error("field opened by a row end");

endmodule
